/* hdl/tbbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket burst pacer package
// Shared types, widths and constants for the pacer and its refill pipeline.
// ----------------------------------------------------------------------------
package tbbp_pkg;

    // Bucket capacity and frame queue depth.
    localparam int BUCKET_BYTES   = 2800;
    localparam int QUEUE_DEPTH    = 8;

    // Register limits.
    localparam int RATE_MIN       = 64;
    localparam int TICK_LIMIT_MAX = 32;
    localparam int REFILL_DIV     = 8000;

    // Field widths.
    localparam int OP_W           = 2;
    localparam int ELAPSED_W      = 32;
    localparam int BYTES_W        = 16;
    localparam int RATE_W         = 20;
    localparam int TICK_CNT_W     = 6;
    localparam int BURST_W        = 4;
    localparam int INTERVAL_W     = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    // Internal bucket width: holds 0..BUCKET_BYTES.
    localparam int BUCKET_W       = $clog2(BUCKET_BYTES + 1);

    // Refill arithmetic. The divide by 8000 is split into a shift by 6 and a
    // multiply by the reciprocal of 125. Products at or above the saturation
    // point always fill the bucket, so only smaller products are divided.
    localparam int PROD_W         = RATE_W + ELAPSED_W;
    localparam longint SAT_PRODUCT = longint'(REFILL_DIV) * longint'(BUCKET_BYTES);
    localparam int PRE_SHIFT      = 6;
    localparam int ODD_DIV        = REFILL_DIV / (1 << PRE_SHIFT);
    localparam int QUOT_IN_W      = $clog2(SAT_PRODUCT / (1 << PRE_SHIFT) + 1);
    localparam int RECIP_SHIFT    = 26;
    localparam int RECIP_MUL      = ((1 << RECIP_SHIFT) + ODD_DIV - 1) / ODD_DIV;
    localparam int RECIP_W        = $clog2(RECIP_MUL + 1);
    localparam int RECIP_PROD_W   = QUOT_IN_W + RECIP_W;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_CHECK   = 2'd1,
        OP_CONSUME = 2'd2,
        OP_EMIT    = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE           = 2'd0,
        REG_TICK_LIMIT     = 2'd1,
        REG_BURST_SIZE     = 2'd2,
        REG_BURST_INTERVAL = 2'd3
    } cfg_reg_t;

    // One input transaction as it travels through the pipeline.
    typedef struct packed {
        op_t                  op;
        logic [ELAPSED_W-1:0] elapsed_us;
        logic [BYTES_W-1:0]   byte_count;
    } item_t;

    // Refill pipeline output: the transaction plus its capped refill amount.
    typedef struct packed {
        item_t                item;
        logic [BUCKET_W-1:0]  refill;
    } refill_t;

endpackage : tbbp_pkg
`default_nettype wire

/* hdl/tbbp_item_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pacer input channel
// Valid/ready channel that carries one pacer command per transaction.
// ----------------------------------------------------------------------------
interface tbbp_item_if;

    logic                           valid;
    logic                           ready;
    logic [tbbp_pkg::OP_W-1:0]      op;
    logic [tbbp_pkg::ELAPSED_W-1:0] elapsed_us;
    logic [tbbp_pkg::BYTES_W-1:0]   byte_count;

    modport source (output valid, output op, output elapsed_us, output byte_count,
                    input ready);
    modport sink   (input valid, input op, input elapsed_us, input byte_count,
                    output ready);

endinterface : tbbp_item_if
`default_nettype wire

/* hdl/tbbp_result_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pacer result channel
// Valid/ready channel that carries one pacer status per transaction.
// ----------------------------------------------------------------------------
interface tbbp_result_if;

    logic                            valid;
    logic                            ready;
    logic                            data_allowed;
    logic [tbbp_pkg::BYTES_W-1:0]    tokens_left;
    logic [tbbp_pkg::TICK_CNT_W-1:0] frames_this_tick;
    logic                            cooldown_active;

    modport source (output valid, output data_allowed, output tokens_left,
                    output frames_this_tick, output cooldown_active, input ready);
    modport sink   (input valid, input data_allowed, input tokens_left,
                    input frames_this_tick, input cooldown_active, output ready);

endinterface : tbbp_result_if
`default_nettype wire

/* hdl/tbbp_refill_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pacer refill pipeline
// Three-stage pipeline that computes rate * elapsed / 8000, capped at the
// bucket size, ahead of the state update. Each stage holds when the stage
// after it is full and stalled.
// ----------------------------------------------------------------------------
module tbbp_refill_pipe (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire tbbp_pkg::item_t               in_item,
    input  wire logic [tbbp_pkg::RATE_W-1:0]   refill_rate,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output tbbp_pkg::refill_t                  out_data
);
    import tbbp_pkg::*;

    logic                      s1_valid_reg;
    item_t                     s1_item_reg;
    logic                      s2_valid_reg;
    item_t                     s2_item_reg;
    logic [PROD_W-1:0]         s2_prod_reg;
    logic                      s3_valid_reg;
    item_t                     s3_item_reg;
    logic                      s3_sat_reg;
    logic [RECIP_PROD_W-1:0]   s3_recip_reg;

    logic                      s1_ready;
    logic                      s2_ready;
    logic                      s3_ready;
    logic [PROD_W-1:0]         s1_prod;
    logic                      s2_sat;
    logic [QUOT_IN_W-1:0]      s2_quot_in;
    logic [RECIP_PROD_W-1:0]   s2_recip;
    logic [BUCKET_W-1:0]       s3_quot;

    // Stage ready chain: a stage takes new data when empty or draining.
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Full-width product of rate and elapsed time.
    assign s1_prod = PROD_W'(refill_rate) * PROD_W'(s1_item_reg.elapsed_us);

    // Saturation test and reciprocal multiply for the divide by 125.
    assign s2_sat     = s2_prod_reg >= PROD_W'(SAT_PRODUCT);
    assign s2_quot_in = s2_prod_reg[PRE_SHIFT +: QUOT_IN_W];
    assign s2_recip   = RECIP_PROD_W'(s2_quot_in) * RECIP_PROD_W'(RECIP_MUL);

    // Quotient and cap.
    assign s3_quot = s3_recip_reg[RECIP_SHIFT +: BUCKET_W];

    assign out_valid       = s3_valid_reg;
    assign out_data.item   = s3_item_reg;
    assign out_data.refill = s3_sat_reg ? BUCKET_W'(BUCKET_BYTES) : s3_quot;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_item_reg <= in_item;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_item_reg <= s1_item_reg;
            s2_prod_reg <= s1_prod;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_item_reg  <= s2_item_reg;
            s3_sat_reg   <= s2_sat;
            s3_recip_reg <= s2_recip;
        end
    end

`ifndef SYNTHESIS
    // Below the saturation point the quotient stays under the bucket size.
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_sat_reg) |-> (s3_quot < BUCKET_W'(BUCKET_BYTES)))
        else $error("refill quotient out of range");

    // A stalled last stage keeps its transaction.
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !out_ready) |=> s3_valid_reg)
        else $error("refill stage dropped a stalled transaction");

    // The input side only stalls when every stage is occupied.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg))
        else $error("refill pipeline stalled with an empty stage");
`endif

endmodule : tbbp_refill_pipe
`default_nettype wire

/* hdl/token_bucket_burst_pacer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Token bucket burst pacer
// Transmit admission pacer with a byte token bucket and a burst cooldown.
// ----------------------------------------------------------------------------
// Usage: each transaction on the item channel is one command: tick (refill
// by rate * elapsed_us / 8000 bytes and count the cooldown down),
// check, consume (drain byte_count bytes) or emit (count a data frame).
// Every command yields exactly one transaction on the result channel with
// the state after the update and whether a data frame may go now.
// A command is accepted, passes three refill pipeline stages (multiply,
// reciprocal multiply, cap), and the state update then writes the output
// register. One command is accepted every cycle unless the result
// channel stalls; the bucket state is read and written in the same
// cycle, so consecutive commands see each other's effects.
// The user writes configuration registers through the plain write port only
// while no command is in flight; the block does not enforce this. Writing
// burst_size or burst_interval_us clears the burst count and the cooldown.
// Reset fills the bucket, clears the counters and loads the default
// registers. When the receiver stalls, the output register holds its
// transaction and the pipeline keeps accepting until all stages are full.
// ----------------------------------------------------------------------------
module token_bucket_burst_pacer_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tbbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tbbp_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    tbbp_item_if.sink                              item,
    tbbp_result_if.source                          result
);
    import tbbp_pkg::*;

    // Configuration registers.
    logic [RATE_W-1:0]       refill_rate_reg;
    logic [TICK_CNT_W-1:0]   tick_limit_reg;
    logic [BURST_W-1:0]      burst_size_reg;
    logic [INTERVAL_W-1:0]   burst_interval_reg;

    // Pacer state.
    logic [BUCKET_W-1:0]     bucket_reg;
    logic [BURST_W-1:0]      burst_count_reg;
    logic [INTERVAL_W-1:0]   cooldown_reg;
    logic [TICK_CNT_W-1:0]   tick_frame_count_reg;

    logic [BUCKET_W-1:0]     bucket_next;
    logic [BURST_W-1:0]      burst_count_next;
    logic [INTERVAL_W-1:0]   cooldown_next;
    logic [TICK_CNT_W-1:0]   tick_frame_count_next;
    logic                    allowed_next;

    // Output register.
    logic                    out_valid_reg;
    logic                    allowed_reg;
    logic [BUCKET_W-1:0]     tokens_reg;
    logic [TICK_CNT_W-1:0]   frames_reg;
    logic                    cooldown_active_reg;

    item_t                   in_item;
    refill_t                 upd;
    logic                    upd_valid;
    logic                    upd_ready;
    logic                    upd_fire;
    cfg_reg_t                cfg_sel;

    logic [BUCKET_W:0]       refill_sum;
    logic [BURST_W-1:0]      burst_inc;
    logic [RATE_W-1:0]       wr_rate;
    logic [TICK_CNT_W-1:0]   wr_limit;
    logic [BURST_W-1:0]      wr_burst;

    assign in_item.op         = op_t'(item.op);
    assign in_item.elapsed_us = item.elapsed_us;
    assign in_item.byte_count = item.byte_count;

    // Refill pipeline ahead of the state update.
    tbbp_refill_pipe u_refill (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (item.valid),
        .in_ready    (item.ready),
        .in_item     (in_item),
        .refill_rate (refill_rate_reg),
        .out_valid   (upd_valid),
        .out_ready   (upd_ready),
        .out_data    (upd)
    );

    // The update stage fires when the output register is free or draining.
    assign upd_ready = !out_valid_reg || result.ready;
    assign upd_fire  = upd_valid && upd_ready;

    // Next state for the command at the update stage.
    always_comb
    begin
        bucket_next           = bucket_reg;
        burst_count_next      = burst_count_reg;
        cooldown_next         = cooldown_reg;
        tick_frame_count_next = tick_frame_count_reg;
        refill_sum            = (BUCKET_W+1)'(bucket_reg) + (BUCKET_W+1)'(upd.refill);
        burst_inc             = burst_count_reg + BURST_W'(1);
        unique case (upd.item.op)
            OP_TICK:
            begin
                if (refill_sum > (BUCKET_W+1)'(BUCKET_BYTES))
                begin
                    bucket_next = BUCKET_W'(BUCKET_BYTES);
                end
                else
                begin
                    bucket_next = refill_sum[BUCKET_W-1:0];
                end
                if (upd.item.elapsed_us >= cooldown_reg)
                begin
                    cooldown_next = '0;
                end
                else
                begin
                    cooldown_next = cooldown_reg - upd.item.elapsed_us;
                end
                tick_frame_count_next = '0;
            end
            OP_CHECK:
            begin
                bucket_next = bucket_reg;
            end
            OP_CONSUME:
            begin
                if (upd.item.byte_count >= BYTES_W'(bucket_reg))
                begin
                    bucket_next = '0;
                end
                else
                begin
                    bucket_next = bucket_reg - upd.item.byte_count[BUCKET_W-1:0];
                end
            end
            OP_EMIT:
            begin
                if (tick_frame_count_reg != '1)
                begin
                    tick_frame_count_next = tick_frame_count_reg + TICK_CNT_W'(1);
                end
                if (burst_inc >= burst_size_reg)
                begin
                    burst_count_next = '0;
                    cooldown_next    = burst_interval_reg;
                end
                else
                begin
                    burst_count_next = burst_inc;
                end
            end
            default:
            begin
                bucket_next = bucket_reg;
            end
        endcase
        allowed_next = (cooldown_next == '0) && (burst_count_next < burst_size_reg) &&
                       (bucket_next != '0) && (tick_frame_count_next < tick_limit_reg);
    end

    // Clamped configuration write values.
    always_comb
    begin
        wr_rate  = cfg_wr_data[RATE_W-1:0];
        wr_limit = cfg_wr_data[TICK_CNT_W-1:0];
        wr_burst = cfg_wr_data[BURST_W-1:0];
        if (wr_rate < RATE_W'(RATE_MIN))
        begin
            wr_rate = RATE_W'(RATE_MIN);
        end
        if (wr_limit == '0)
        begin
            wr_limit = TICK_CNT_W'(1);
        end
        else if (wr_limit > TICK_CNT_W'(TICK_LIMIT_MAX))
        begin
            wr_limit = TICK_CNT_W'(TICK_LIMIT_MAX);
        end
        if (wr_burst == '0)
        begin
            wr_burst = BURST_W'(1);
        end
        else if (wr_burst > BURST_W'(QUEUE_DEPTH))
        begin
            wr_burst = BURST_W'(QUEUE_DEPTH);
        end
    end

    assign cfg_sel = cfg_reg_t'(cfg_index);

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refill_rate_reg    <= RATE_W'(RATE_MIN);
            tick_limit_reg     <= TICK_CNT_W'(1);
            burst_size_reg     <= BURST_W'(1);
            burst_interval_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_sel)
                REG_RATE:           refill_rate_reg    <= wr_rate;
                REG_TICK_LIMIT:     tick_limit_reg     <= wr_limit;
                REG_BURST_SIZE:     burst_size_reg     <= wr_burst;
                REG_BURST_INTERVAL: burst_interval_reg <= cfg_wr_data[INTERVAL_W-1:0];
                default:            refill_rate_reg    <= refill_rate_reg;
            endcase
        end
    end

    // Pacer state; burst register writes restart the burst.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_reg           <= BUCKET_W'(BUCKET_BYTES);
            burst_count_reg      <= '0;
            cooldown_reg         <= '0;
            tick_frame_count_reg <= '0;
        end
        else if (upd_fire)
        begin
            bucket_reg           <= bucket_next;
            burst_count_reg      <= burst_count_next;
            cooldown_reg         <= cooldown_next;
            tick_frame_count_reg <= tick_frame_count_next;
        end
        else if (cfg_wr_en && (cfg_sel == REG_BURST_SIZE || cfg_sel == REG_BURST_INTERVAL))
        begin
            burst_count_reg <= '0;
            cooldown_reg    <= '0;
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (upd_ready)
        begin
            out_valid_reg <= upd_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            allowed_reg         <= allowed_next;
            tokens_reg          <= bucket_next;
            frames_reg          <= tick_frame_count_next;
            cooldown_active_reg <= (cooldown_next != '0);
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.data_allowed     = allowed_reg;
    assign result.tokens_left      = BYTES_W'(tokens_reg);
    assign result.frames_this_tick = frames_reg;
    assign result.cooldown_active  = cooldown_active_reg;

`ifndef SYNTHESIS
    // The bucket never holds more than its capacity.
    a_bucket_cap: assert property (@(posedge clk) disable iff (!rst_n)
        bucket_reg <= BUCKET_W'(BUCKET_BYTES))
        else $error("bucket above capacity");

    // A full burst always wraps the burst count.
    a_burst_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        burst_count_reg < burst_size_reg)
        else $error("burst count reached burst size");

    // A tick clears the per-tick frame count.
    a_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && upd.item.op == OP_TICK) |=> (tick_frame_count_reg == '0))
        else $error("tick did not clear frame count");

    // The per-tick limit stays inside its clamped range.
    a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_limit_reg != '0) && (tick_limit_reg <= TICK_CNT_W'(TICK_LIMIT_MAX)))
        else $error("frame limit out of range");
`endif

endmodule : token_bucket_burst_pacer_unit
`default_nettype wire
